// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
    else $error("assertion failed");
// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`endif

// ----- hdl/vptk_pkg.sv -----
// constants, types and mapping functions for the top-k value profiler
// no dependencies
package vptk_pkg;
  localparam int unsigned NumSites = 64;
  localparam int unsigned ValuesPerSite = 8;
  localparam int unsigned PoolNodes = 1024;
  localparam int unsigned SiteW = $clog2(NumSites);
  localparam int unsigned SlotW = $clog2(ValuesPerSite);
  localparam int unsigned FillW = $clog2(ValuesPerSite + 1);
  localparam int unsigned AddrW = SiteW + SlotW;
  localparam int unsigned PoolW = $clog2(PoolNodes);
  localparam int unsigned Depth = NumSites * ValuesPerSite;

  localparam logic [63:0] BucketExactTop = 64'd8;
  localparam logic [63:0] BucketLast = 64'd513;
  localparam logic [63:0] S64Min = 64'h8000_0000_0000_0000;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ActPlain = 2'd0,
    ActRange = 2'd1,
    ActBucket = 2'd2,
    ActSpare = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    OutHit = 3'd0,
    OutNew = 3'd1,
    OutReplaced = 3'd2,
    OutDecremented = 3'd3,
    OutExhausted = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StDecide,
    StOut
  } state_e;

  function automatic logic [63:0] range_map(logic [63:0] v, logic [63:0] s,
                                            logic [63:0] l, logic [63:0] g);
    logic [63:0] r;
    if (g != S64Min && !($signed(v) < $signed(g))) r = g;
    else if ($signed(v) < $signed(s) || $signed(l) < $signed(v)) r = l + 64'd1;
    else r = v;
    return r;
  endfunction

  // only values 9..512 reach the power-of-two search, so ten bits suffice
  function automatic logic [63:0] bucket_map(logic [63:0] v);
    logic [63:0] r;
    logic [9:0] top;
    top = '0;
    for (int b = 0; b < 10; b++) begin
      if (v[b]) top = 10'(1 << b);
    end
    if (v <= BucketExactTop) r = v;
    else if (v >= BucketLast) r = BucketLast;
    else if ((v & (v - 64'd1)) == 64'd0) r = v;
    else r = {54'd0, top} + 64'd1;
    return r;
  endfunction
endpackage

// ----- hdl/vptk_entry_ram.sv -----
// entry store: value and count per site slot, one read and one write port
// depends on vptk_pkg
module vptk_entry_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [vptk_pkg::AddrW-1:0] waddr_i,
  input  logic [63:0]                wvalue_i,
  input  logic [31:0]                wcount_i,
  input  logic [vptk_pkg::AddrW-1:0] raddr_i,
  output logic [63:0]                rvalue_o,
  output logic [31:0]                rcount_o
);
  import vptk_pkg::*;
  logic [95:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= {wcount_i, wvalue_i};
    {rcount_o, rvalue_o} <= mem[raddr_i];
  end
endmodule

// ----- hdl/value_profile_topk_counter_core.sv -----
// top-k value profiler core: mapping, site scan sequencer, fill store, entry store
// depends on vptk_pkg and vptk_entry_ram
//
// Usage: one item enters on the input channel (valid/ready), carrying an
// action, a site and a 64-bit value plus range bounds. One result item leaves
// on the output channel per input item. The core works on one item at a
// time: the site's fill is read from the fill store at acceptance, then a map
// step also reads the first stored entry, then a scan reads one stored entry
// per cycle through the single entry store read port until a hit or the end
// of the site's fill, then a decide and write-back step and an output state.
// The result is held in an output register until taken; while the receiver
// stalls, the core holds input ready low. Reset clears the per-site fill
// valid bits and the pool counter at once; neither store is cleared since a
// site without its valid bit reads as empty and slots at or above a site's
// fill are never used, so items are taken from the first cycle after reset.
module value_profile_topk_counter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [5:0]  site_i,
  input  logic [63:0] target_value_i,
  input  logic [63:0] range_start_i,
  input  logic [63:0] range_last_i,
  input  logic [63:0] large_threshold_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  outcome_o,
  output logic [63:0] recorded_value_o,
  output logic [31:0] count_after_o
);
  import vptk_pkg::*;

  state_e state_q, state_d;
  logic [FillW-1:0] fill_mem [NumSites];
  logic [NumSites-1:0] fill_vld_q;
  logic [FillW-1:0] fill_rd_q, cur_fill;
  logic [PoolW-1:0] pool_q;
  logic [SiteW-1:0] site_q;
  logic [63:0] value_q, value_raw_q, rs_q, rl_q, lt_q;
  logic [1:0] act_q;
  logic [FillW-1:0] sfill_q, idx_q;
  logic [SlotW-1:0] least_q;
  logic [31:0] least_cnt_q;
  logic [63:0] least_val_q;
  logic hit_q;
  logic [SlotW-1:0] hit_slot_q;
  logic [31:0] hit_cnt_q;
  logic [2:0] outcome_q;
  logic [31:0] cnt_q;
  logic grant_new;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [63:0] wvalue, rvalue;
  logic [31:0] wcount, rcount;

  vptk_entry_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wvalue_i(wvalue), .wcount_i(wcount),
    .raddr_i(raddr), .rvalue_o(rvalue), .rcount_o(rcount)
  );

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign outcome_o = outcome_q;
  assign recorded_value_o = value_q;
  assign count_after_o = cnt_q;
  assign raddr = {site_q, idx_q[SlotW-1:0]};
  // a site never written reads as empty
  assign cur_fill = fill_vld_q[site_q] ? fill_rd_q : '0;
  assign grant_new = (state_q == StDecide) && !hit_q
                     && sfill_q < FillW'(ValuesPerSite)
                     && 32'(pool_q) + 32'd1 < 32'(PoolNodes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  // read data arrives in the cycle after its read, tagged by rd_slot_q
  logic rd_valid_q;
  logic [SlotW-1:0] rd_slot_q;
  logic [FillW-1:0] idx_d;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StRead;
      StRead: begin
        idx_d = FillW'(1);
        state_d = StScan;
      end
      StScan: begin
        if (!rd_valid_q || rvalue == value_q) state_d = StDecide;
        if (idx_q < sfill_q) idx_d = idx_q + FillW'(1);
      end
      StDecide: state_d = StOut;
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // decision logic
  logic [31:0] dec_cnt;
  always_comb begin
    we = 1'b0;
    waddr = {site_q, least_q};
    wvalue = value_q;
    wcount = 32'd1;
    dec_cnt = (least_cnt_q != 32'd0) ? least_cnt_q - 32'd1 : 32'd0;
    if (state_q == StDecide) begin
      if (hit_q) begin
        we = 1'b1;
        waddr = {site_q, hit_slot_q};
        wvalue = value_q;
        wcount = (hit_cnt_q != CountMax) ? hit_cnt_q + 32'd1 : hit_cnt_q;
      end else if (sfill_q >= FillW'(ValuesPerSite)) begin
        we = 1'b1;
        waddr = {site_q, least_q};
        if (dec_cnt == 32'd0) begin
          wvalue = value_q;
          wcount = 32'd1;
        end else begin
          wvalue = least_val_q;
          wcount = dec_cnt;
        end
      end else if (grant_new) begin
        we = 1'b1;
        waddr = {site_q, sfill_q[SlotW-1:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= '0;
      rd_valid_q <= 1'b0;
      fill_vld_q <= '0;
    end else begin
      if (state_q == StRead) rd_valid_q <= (cur_fill != '0);
      else if (state_q == StScan)
        rd_valid_q <= (idx_q < sfill_q) && !(rd_valid_q && rvalue == value_q);
      else rd_valid_q <= 1'b0;
      if (grant_new) begin
        pool_q <= pool_q + PoolW'(1);
        fill_vld_q[site_q] <= 1'b1;
      end
    end
  end

  // fill store, read at the address of the item being offered
  always_ff @(posedge clk_i) begin
    if (grant_new) fill_mem[site_q] <= sfill_q + FillW'(1);
    if (state_q == StIdle) fill_rd_q <= fill_mem[site_i];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        act_q <= action_i;
        site_q <= SiteW'(site_i);
        value_raw_q <= target_value_i;
        rs_q <= range_start_i;
        rl_q <= range_last_i;
        lt_q <= large_threshold_i;
        idx_q <= '0;
      end
      StRead: begin
        unique case (action_e'(act_q))
          ActRange: value_q <= range_map(value_raw_q, rs_q, rl_q, lt_q);
          ActBucket: value_q <= bucket_map(value_raw_q);
          default: value_q <= value_raw_q;
        endcase
        sfill_q <= cur_fill;
        hit_q <= 1'b0;
        idx_q <= idx_d;
        rd_slot_q <= '0;
      end
      StScan: begin
        idx_q <= idx_d;
        rd_slot_q <= idx_q[SlotW-1:0];
        if (rd_valid_q) begin
          if (rvalue == value_q) begin
            hit_q <= 1'b1;
            hit_slot_q <= rd_slot_q;
            hit_cnt_q <= rcount;
          end else if (rd_slot_q == '0 || rcount < least_cnt_q) begin
            least_q <= rd_slot_q;
            least_cnt_q <= rcount;
            least_val_q <= rvalue;
          end
        end
      end
      StDecide: begin
        if (hit_q) begin
          outcome_q <= OutHit;
          cnt_q <= wcount;
        end else if (sfill_q >= FillW'(ValuesPerSite)) begin
          outcome_q <= (dec_cnt == 32'd0) ? OutReplaced : OutDecremented;
          cnt_q <= (dec_cnt == 32'd0) ? 32'd1 : dec_cnt;
        end else if (grant_new) begin
          outcome_q <= OutNew;
          cnt_q <= 32'd1;
        end else begin
          outcome_q <= OutExhausted;
          cnt_q <= 32'd0;
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- hdl/vptk_checker.sv -----
// port-level checks on the profiler core, bound into the core module
// depends on assert_macros.svh and vptk_pkg
`include "assert_macros.svh"
module vptk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  outcome_o,
  input logic [31:0] count_after_o
);
  import vptk_pkg::*;

  `ASSERT_NEVER(no_overlap, clk_i, rst_ni, out_valid_o && in_ready_o)
  `ASSERT_IMPL(busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `ASSERT_IMPL(out_holds, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_after_o))
  `ASSERT_IMPL(drop_zero, clk_i, rst_ni,
    out_valid_o && outcome_o == OutExhausted |-> count_after_o == 32'd0)
  `ASSERT_IMPL(count_nonzero, clk_i, rst_ni,
    out_valid_o && outcome_o != OutExhausted |-> count_after_o != 32'd0)
endmodule

bind value_profile_topk_counter_core vptk_checker u_vptk_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .outcome_o, .count_after_o
);

// ----- tb/sv/value_profile_topk_counter_core_test.sv -----
// testbench for the top-k value profiler core: directed table, then random items
// in four idle/stall phases, checked against table entries or a behavioural profile model
// depends on vptk_pkg and value_profile_topk_counter_core
`timescale 1ns / 1ps

module value_profile_topk_counter_core_test;
  import vptk_pkg::*;

  localparam int unsigned RunLimit = 400000;
  localparam int unsigned RandomItems = 1930;

  typedef struct {
    action_e     act;
    logic [5:0]  site;
    logic [63:0] val;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] cap;
    bit          typed;
    outcome_e    oc;
    logic [63:0] rec;
    logic [31:0] cnt;
  } item_t;

  typedef struct {
    outcome_e    oc;
    logic [63:0] rec;
    logic [31:0] cnt;
  } tally_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [5:0]  site_i;
  logic [63:0] target_value_i;
  logic [63:0] range_start_i;
  logic [63:0] range_last_i;
  logic [63:0] large_threshold_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  outcome_o;
  logic [63:0] recorded_value_o;
  logic [31:0] count_after_o;

  // profile model state
  int unsigned site_used [NumSites];
  logic [63:0] slot_value [Depth];
  logic [31:0] slot_count [Depth];
  int unsigned nodes_taken;

  tally_t      pending_tallies [$];
  int          failures;
  int          idle_pct;
  int          stall_pct;
  int unsigned cycles;

  value_profile_topk_counter_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .site_i            (site_i),
    .target_value_i    (target_value_i),
    .range_start_i     (range_start_i),
    .range_last_i      (range_last_i),
    .large_threshold_i (large_threshold_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .outcome_o         (outcome_o),
    .recorded_value_o  (recorded_value_o),
    .count_after_o     (count_after_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] clamp_value(logic [63:0] v, logic [63:0] lo,
                                              logic [63:0] hi, logic [63:0] cap);
    if (cap != S64Min && $signed(v) >= $signed(cap)) return cap;
    if ($signed(v) < $signed(lo) || $signed(v) > $signed(hi)) return hi + 64'd1;
    return v;
  endfunction

  function automatic logic [63:0] size_bucket(logic [63:0] v);
    int msb;
    if (v <= BucketExactTop) return v;
    if (v >= BucketLast) return BucketLast;
    msb = 0;
    for (int b = 0; b < 10; b++) begin
      if (v[b]) msb = b;
    end
    if (v == (64'd1 << msb)) return v;
    return (64'd1 << msb) + 64'd1;
  endfunction

  task automatic profile_item(input item_t it, output tally_t t);
    int unsigned base, fill, least;
    logic [31:0] least_cnt;
    logic [63:0] v;
    base = it.site * ValuesPerSite;
    fill = site_used[it.site];
    least = base;
    least_cnt = '0;
    case (it.act)
      ActRange:  v = clamp_value(it.val, it.lo, it.hi, it.cap);
      ActBucket: v = size_bucket(it.val);
      default:   v = it.val;
    endcase
    t.rec = v;
    for (int unsigned i = 0; i < fill; i++) begin
      if (slot_value[base + i] == v) begin
        if (slot_count[base + i] != CountMax) slot_count[base + i]++;
        t.oc = OutHit;
        t.cnt = slot_count[base + i];
        return;
      end
      if (i == 0 || slot_count[base + i] < least_cnt) begin
        least = base + i;
        least_cnt = slot_count[base + i];
      end
    end
    if (fill >= ValuesPerSite) begin
      if (least_cnt != 0) slot_count[least] = least_cnt - 32'd1;
      if (slot_count[least] == 0) begin
        slot_value[least] = v;
        slot_count[least] = 32'd1;
        t.oc = OutReplaced;
      end else begin
        t.oc = OutDecremented;
      end
      t.cnt = slot_count[least];
    end else if (nodes_taken + 1 < PoolNodes) begin
      nodes_taken++;
      slot_value[base + fill] = v;
      slot_count[base + fill] = 32'd1;
      site_used[it.site] = fill + 1;
      t.oc = OutNew;
      t.cnt = 32'd1;
    end else begin
      t.oc = OutExhausted;
      t.cnt = '0;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly a few busy sites and a skewed small value set, so sites fill and churn
  function automatic item_t random_item();
    item_t it;
    int pick;
    it.act = action_e'($urandom_range(3));
    it.site = ($urandom_range(99) < 80) ? 6'($urandom_range(5)) : 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) it.val = 64'($urandom_range(3));
    else if (pick < 80) it.val = 64'($urandom_range(14));
    else if (pick < 90) it.val = 64'($urandom_range(700));
    else it.val = rand64();
    if ($urandom_range(1)) begin
      it.lo = 64'($signed($urandom_range(20)) - 10);
      it.hi = it.lo + 64'($urandom_range(12));
      it.cap = ($urandom_range(2) == 0) ? S64Min : 64'($urandom_range(30));
    end else begin
      it.lo = rand64();
      it.hi = rand64();
      it.cap = rand64();
    end
    it.typed = 1'b0;
    it.oc = OutHit;
    it.rec = '0;
    it.cnt = '0;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    tally_t t;
    action_i <= it.act;
    site_i <= it.site;
    target_value_i <= it.val;
    range_start_i <= it.lo;
    range_last_i <= it.hi;
    large_threshold_i <= it.cap;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    profile_item(it, t);
    if (it.typed) begin
      t.oc = it.oc;
      t.rec = it.rec;
      t.cnt = it.cnt;
    end
    pending_tallies.push_back(t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // receiver side: check on handshake, then pick ready for the next edge
  initial begin
    tally_t t;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_tallies.size() == 0) begin
          $error("result item with nothing expected");
          failures++;
        end else begin
          t = pending_tallies.pop_front();
          if (outcome_o !== t.oc) begin
            $error("outcome: expected %0d, got %0d", t.oc, outcome_o);
            failures++;
          end
          if (recorded_value_o !== t.rec) begin
            $error("recorded_value: expected %h, got %h", t.rec, recorded_value_o);
            failures++;
          end
          if (count_after_o !== t.cnt) begin
            $error("count_after: expected %0d, got %0d", t.cnt, count_after_o);
            failures++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > RunLimit) begin
        $display("FAIL value_profile_topk_counter_core");
        $finish;
      end
    end
  end

  initial begin
    item_t plan [$];
    item_t it;
    int phase_len;
    failures = 0;
    idle_pct = 0;
    stall_pct = 0;
    nodes_taken = 0;
    foreach (site_used[s]) site_used[s] = 0;
    foreach (slot_value[s]) begin
      slot_value[s] = '0;
      slot_count[s] = '0;
    end
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    action_i = '0;
    site_i = '0;
    target_value_i = '0;
    range_start_i = '0;
    range_last_i = '0;
    large_threshold_i = '0;

    // plain, spare action, range clamp and size bucket cases, then replacement cases and a new site-63 entry
    plan.push_back('{ActPlain, 6'd0, 64'd0, 0, 0, 0, 1, OutNew, 64'd0, 32'd1});
    plan.push_back('{ActPlain, 6'd0, 64'd0, 0, 0, 0, 1, OutHit, 64'd0, 32'd2});
    plan.push_back('{ActPlain, 6'd0, '1, 0, 0, 0, 1, OutNew, '1, 32'd1});
    plan.push_back('{ActSpare, 6'd0, 64'd0, '1, '1, '1, 1, OutHit, 64'd0, 32'd3});
    plan.push_back('{ActRange, 6'd1, 64'd100, 64'd0, 64'd50, S64Min, 1, OutNew, 64'd51,
                     32'd1});
    plan.push_back('{ActRange, 6'd1, S64Min, -64'sd5, 64'd5, S64Min, 1, OutNew, 64'd6,
                     32'd1});
    plan.push_back('{ActRange, 6'd1, 64'd200, 64'd0, 64'd50, 64'd100, 1, OutNew, 64'd100,
                     32'd1});
    plan.push_back('{ActRange, 6'd1, 64'd3, -64'sd5, 64'd5, S64Min, 1, OutNew, 64'd3,
                     32'd1});
    plan.push_back('{ActRange, 6'd1, -64'sd10, 64'd0, ~S64Min, S64Min, 1, OutNew, S64Min,
                     32'd1});
    plan.push_back('{ActRange, 6'd1, ~S64Min, 64'd0, ~S64Min, ~S64Min, 0, OutHit, 0, 0});
    plan.push_back('{ActBucket, 6'd2, 64'd8, 0, 0, 0, 1, OutNew, 64'd8, 32'd1});
    plan.push_back('{ActBucket, 6'd2, 64'd9, 0, 0, 0, 1, OutNew, 64'd9, 32'd1});
    plan.push_back('{ActBucket, 6'd2, 64'd512, 0, 0, 0, 1, OutNew, 64'd512, 32'd1});
    plan.push_back('{ActBucket, 6'd2, 64'd513, 0, 0, 0, 1, OutNew, 64'd513, 32'd1});
    plan.push_back('{ActBucket, 6'd2, '1, 0, 0, 0, 1, OutHit, 64'd513, 32'd2});
    plan.push_back('{ActBucket, 6'd2, 64'd300, 0, 0, 0, 1, OutNew, 64'd257, 32'd1});
    plan.push_back('{ActBucket, 6'd2, 64'd0, 0, 0, 0, 1, OutNew, 64'd0, 32'd1});
    plan.push_back('{ActBucket, 6'd2, 64'd1, 0, 0, 0, 1, OutNew, 64'd1, 32'd1});
    plan.push_back('{ActBucket, 6'd2, 64'd2, 0, 0, 0, 1, OutNew, 64'd2, 32'd1});
    // site 2 is full: its first least entry drops to zero and is taken over
    plan.push_back('{ActPlain, 6'd2, 64'd77, 0, 0, 0, 1, OutReplaced, 64'd77, 32'd1});
    plan.push_back('{ActPlain, 6'd2, 64'd77, 0, 0, 0, 1, OutHit, 64'd77, 32'd2});
    plan.push_back('{ActPlain, 6'd2, 64'd78, 0, 0, 0, 0, OutHit, 0, 0});
    plan.push_back('{ActPlain, 6'd63, 64'h5555_aaaa_0f0f_f0f0, 0, 0, 0, 1, OutNew,
                     64'h5555_aaaa_0f0f_f0f0, 32'd1});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) send_item(plan[r]);

    phase_len = RandomItems / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < phase_len; n++) begin
        it = random_item();
        send_item(it);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (failures == 0 && pending_tallies.size() == 0) begin
      $display("PASS value_profile_topk_counter_core");
    end else begin
      $display("FAIL value_profile_topk_counter_core");
    end
    $finish;
  end

endmodule
